// ===== design/fbpq_pkg.sv =====
`default_nettype none

package fbpq_pkg;

   // Request codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_PEEK_FRONT = 3'd3;
   localparam logic [2:0] OP_EMPTY_Q    = 3'd4;
   localparam logic [2:0] OP_DUMP       = 3'd5;

   // Result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam int unsigned WORD_W = 32;

   typedef logic [WORD_W-1:0] word_type;

endpackage

`default_nettype wire

// ===== design/fbpq_store.sv =====
`default_nettype none

module fbpq_store
   import fbpq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire word_type                 wr_data,
   output word_type                      rd_data
);

   word_type mem [DEPTH];
   word_type rd_data_ff;

   // Write one word, or read one word into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/fbpq_ctrl.sv =====
`default_nettype none

module fbpq_ctrl
   import fbpq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [2:0]               req_type,
   input  wire word_type                 req_word,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_status,
   output word_type                      rsp_word,
   output logic                          rsp_last,
   output logic                          mem_wr_en,
   output logic                          mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]      mem_addr,
   output word_type                      mem_wr_data,
   input  wire word_type                 mem_rd_data
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W = CNT_W + 1;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_FETCH = 5'b00100,
      S_READ  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [2:0]        op_ff, op_in;
   word_type          word_ff, word_in;
   logic [1:0]        status_ff, status_in;
   word_type          value_ff, value_in;
   logic              last_ff, last_in;

   logic [CNT_W-1:0]  ring_off;
   logic [SUM_W-1:0]  ring_sum;
   logic [IDX_W-1:0]  ring_pos;
   logic              is_full;
   logic              is_empty;
   logic              is_push;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign is_push  = (op_ff == OP_PUSH_FRONT) || (op_ff == OP_PUSH_BACK);

   // Pick the ring offset for the shared position unit
   always_comb begin
      ring_off = idx_ff;
      unique case (state_ff)
         S_EXEC: begin
            if (op_ff == OP_PUSH_FRONT) begin
               ring_off = CNT_W'(DEPTH - 1);
            end else begin
               ring_off = count_ff;
            end
         end
         S_READ:  ring_off = CNT_W'(1);
         default: ring_off = idx_ff;
      endcase
   end

   // Shared ring position unit: add, then wrap with one compare and subtract
   always_comb begin
      ring_sum = SUM_W'(head_ff) + SUM_W'(ring_off);
      if (ring_sum >= SUM_W'(DEPTH)) begin
         ring_sum = ring_sum - SUM_W'(DEPTH);
      end
      ring_pos = ring_sum[IDX_W-1:0];
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      op_in       = op_ff;
      word_in     = word_ff;
      status_in   = status_ff;
      value_in    = value_ff;
      last_in     = last_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_addr    = ring_pos;
      mem_wr_data = word_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Take the request word
            if (req_valid) begin
               op_in    = req_type;
               word_in  = req_word;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_OK;
            value_in  = '0;
            last_in   = 1'b1;
            idx_in    = '0;
            priority if (is_push) begin
               if (is_full) begin
                  status_in = ST_FULL;
                  state_in  = S_RESP;
               end else begin
                  mem_wr_en = 1'b1;
                  if (op_ff == OP_PUSH_FRONT) begin
                     head_in = ring_pos;
                  end
                  count_in = count_ff + CNT_W'(1);
                  state_in = S_IDLE;
               end
            end else if (op_ff == OP_POP_FRONT || op_ff == OP_PEEK_FRONT ||
                         op_ff == OP_DUMP) begin
               if (is_empty) begin
                  status_in = ST_EMPTY;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_FETCH;
               end
            end else if (op_ff == OP_EMPTY_Q) begin
               value_in = word_type'(is_empty);
               state_in = S_RESP;
            end else begin
               // Drop unused request codes
               state_in = S_IDLE;
            end
         end
         S_FETCH: begin
            mem_rd_en = 1'b1;
            state_in  = S_READ;
         end
         S_READ: begin
            status_in = ST_OK;
            value_in  = mem_rd_data;
            if (op_ff == OP_DUMP) begin
               last_in = (idx_ff + CNT_W'(1) == count_ff);
            end else begin
               last_in = 1'b1;
            end
            // Advance the head on a pop
            if (op_ff == OP_POP_FRONT) begin
               head_in  = ring_pos;
               count_in = count_ff - CNT_W'(1);
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            // Hold the result word until taken
            if (rsp_ready) begin
               if (op_ff == OP_DUMP && !last_ff && status_ff == ST_OK) begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_FETCH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      op_ff     <= op_in;
      word_ff   <= word_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_status = status_ff;
   assign rsp_word   = value_ff;
   assign rsp_last   = last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy exceeds depth");

   a_write_not_full: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !is_full)
      else $error("write into full store");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not grow occupancy");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_last)
      else $error("error status not marked last");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      mem_rd_en |-> !is_empty)
      else $error("read from empty store");
`endif

endmodule

`default_nettype wire

// ===== design/front_back_push_queue.sv =====
`default_nettype none
// Push: the EXEC state after accept writes the store; the next request is taken back in IDLE.
// Empty query, full push and empty pop/peek/dump: result goes from EXEC straight to RESP.
// Pop, peek: result valid after the EXEC, FETCH and READ states (one registered store read).
// Dump: first word via EXEC, FETCH, READ; after each word is taken, the next via FETCH, READ.
// One request at a time; the sequencer and its ring position adder set the pace.
// Synchronous active-high reset empties the queue; stored words stay undefined.

module front_back_push_queue
   import fbpq_pkg::*;
#(
   parameter int unsigned DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_type,
   input  wire logic signed [31:0] req_push_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic signed [31:0]      rsp_out_value,
   output logic                    rsp_last
);

   localparam int unsigned IDX_W = $clog2(DEPTH);

   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_addr;
   word_type          mem_wr_data;
   word_type          mem_rd_data;
   word_type          rsp_word;

   fbpq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_type    (req_type),
      .req_word    (word_type'(req_push_value)),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_word    (rsp_word),
      .rsp_last    (rsp_last),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   fbpq_store #(
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   assign rsp_out_value = $signed(rsp_word);

endmodule

`default_nettype wire
